// ----- src/rmv_pkg.sv -----
package rmv_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF  = 32;

    localparam int SAMPLE_FIELD_W   = 32;
    localparam int COUNT_FIELD_W    = 32;
    localparam int MEAN_FIELD_W     = 32;
    localparam int MOMENT_W         = 64;
    localparam int ROOT_W           = MOMENT_W / 2;
    localparam int STD_FIELD_W      = 32;

    localparam int COUNT_LSB        = 0;
    localparam int MEAN_LSB         = COUNT_LSB + COUNT_FIELD_W;
    localparam int MOMENT_LSB       = MEAN_LSB + MEAN_FIELD_W;
    localparam int STD_LSB          = MOMENT_LSB + MOMENT_W;
    localparam int OUT_DATA_W       = STD_LSB + STD_FIELD_W;

endpackage

// ----- src/rmv_div.sv -----
module rmv_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(NUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] num_next;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_next = {num_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && (step_reg == LAST_STEP);
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// ----- src/rmv_mul.sv -----
module rmv_mul #(
    parameter int W = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   op_a,
    input  logic [W-1:0]   op_b,
    output logic           done,
    output logic [2*W-1:0] product
);

    localparam int STEP_W = $clog2(W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [W-1:0]      a_reg;
    logic [W-1:0]      b_reg;
    logic [2*W-1:0]    p_reg;

    logic [W:0]        sum;
    logic [2*W-1:0]    p_next;

    // shift-add, one multiplier bit per cycle
    always_comb begin
        sum    = {1'b0, p_reg[2*W-1:W]} + (b_reg[0] ? {1'b0, a_reg} : '0);
        p_next = {sum, p_reg[W-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && (step_reg == LAST_STEP);
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= op_a;
            b_reg <= op_b;
            p_reg <= '0;
        end else if (busy_reg) begin
            b_reg <= {1'b0, b_reg[W-1:1]};
            p_reg <= p_next;
        end
    end

    assign done    = done_reg;
    assign product = p_reg;

endmodule

// ----- src/rmv_sqrt.sv -----
module rmv_sqrt #(
    parameter int RW = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [2*RW-1:0] radicand,
    output logic            done,
    output logic [RW-1:0]   root
);

    localparam int STEP_W = $clog2(RW);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RW - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [2*RW-1:0]   v_reg;
    logic [RW+1:0]     r_reg;
    logic [RW-1:0]     q_reg;

    logic [RW+3:0]     trial;
    logic [RW+3:0]     test;
    logic [RW+3:0]     diff;
    logic              ge;

    // one root bit per cycle, two radicand bits shifted in
    always_comb begin
        trial = {r_reg, v_reg[2*RW-1 -: 2]};
        test  = {2'b00, q_reg, 2'b01};
        diff  = trial - test;
        ge    = trial >= test;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && (step_reg == LAST_STEP);
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg <= radicand;
            r_reg <= '0;
            q_reg <= '0;
        end else if (busy_reg) begin
            v_reg <= {v_reg[2*RW-3:0], 2'b00};
            r_reg <= ge ? diff[RW+1:0] : trial[RW+1:0];
            q_reg <= {q_reg[RW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = q_reg;

endmodule

// ----- src/running_mean_variance_top.sv -----
// Running mean and variance (Welford) over a stream of signed fixed-point samples.
// Input channel s_*: one beat carries one sample in s_tdata (low SAMPLE_WIDTH bits
// used, two's complement). Output channel m_*: one beat per sample with count,
// mean, second moment and standard deviation in m_tdata, and in m_tuser a flag
// that is high once at least two samples were taken.
// One sample is processed at a time. An input beat passes through the bit-serial
// divider for the mean step, the serial multiplier, the 64-bit moment divider and
// the root unit before its output beat is formed; for the first sample the moment
// divider and the root unit are skipped. The block returns to idle and takes the
// next sample once the result is loaded into the output register, so it accepts
// no new sample before it is through with the last one.
// Reset clears count, mean and second moment and drops m_tvalid.
// A stalled receiver holds the result in the output register; the block takes one
// more sample and computes it, then waits until the held beat is taken.
module running_mean_variance_top #(
    parameter int SAMPLE_WIDTH = rmv_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = rmv_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rmv_pkg::SAMPLE_FIELD_W-1:0] s_tdata,  // sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rmv_pkg::OUT_DATA_W-1:0] m_tdata,  // count, mean, second_moment, std_dev
    output logic [0:0]                    m_tuser    // std_dev_valid
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = COUNT_WIDTH;
    localparam int MW    = rmv_pkg::MOMENT_W;
    localparam int SUM_W = MW + 1;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_LOAD    = 4'd1;
    localparam logic [3:0] ST_DIV1    = 4'd2;
    localparam logic [3:0] ST_MUL_GO  = 4'd3;
    localparam logic [3:0] ST_MUL     = 4'd4;
    localparam logic [3:0] ST_ACC     = 4'd5;
    localparam logic [3:0] ST_VAR_GO  = 4'd6;
    localparam logic [3:0] ST_DIV2    = 4'd7;
    localparam logic [3:0] ST_SQRT_GO = 4'd8;
    localparam logic [3:0] ST_SQRT    = 4'd9;
    localparam logic [3:0] ST_OUT     = 4'd10;

    logic [3:0]    state_reg;
    logic [3:0]    state_next;

    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] mean_reg;
    logic [MW-1:0] m2_reg;

    logic [SW-1:0] x_reg;
    logic          d0_neg_reg;
    logic [SW-1:0] a_reg;
    logic          d1_neg_reg;
    logic          b_nz_reg;
    logic [rmv_pkg::ROOT_W-1:0] sd_reg;

    logic          out_valid_reg;
    logic [rmv_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic          out_flag_reg;

    logic signed [SW:0] d0;
    logic signed [SW:0] d1;
    logic [SW:0]   d0_mag;
    logic [SW:0]   d1_mag;
    logic [SW-1:0] step_q;
    logic [SW-1:0] mean_new;
    logic [2*SW-1:0] prod;
    logic [MW-1:0] term;
    logic [SUM_W-1:0] m2_sum;
    logic          sd_ok;
    logic          out_free;

    logic          div1_start;
    logic          div1_done;
    logic [SW-1:0] div1_q;
    logic          mul_start;
    logic          mul_done;
    logic          div2_start;
    logic          div2_done;
    logic [MW-1:0] div2_q;
    logic          sqrt_start;
    logic          sqrt_done;
    logic [rmv_pkg::ROOT_W-1:0] sqrt_root;

    always_comb begin
        d0       = $signed({x_reg[SW-1], x_reg}) - $signed({mean_reg[SW-1], mean_reg});
        d1       = $signed({x_reg[SW-1], x_reg}) - $signed({mean_reg[SW-1], mean_reg});
        d0_mag   = d0[SW] ? -d0 : d0;
        d1_mag   = d1[SW] ? -d1 : d1;
        step_q   = d0_neg_reg ? -div1_q : div1_q;
        mean_new = mean_reg + step_q;
        if ((d0_neg_reg != d1_neg_reg) && (a_reg != '0) && b_nz_reg) begin
            term = '0;
        end else begin
            term = MW'(prod);
        end
        m2_sum   = {1'b0, m2_reg} + SUM_W'(term);
        sd_ok    = |cnt_reg[CW-1:1];
        out_free = !out_valid_reg || m_tready;
    end

    assign div1_start = (state_reg == ST_LOAD);
    assign mul_start  = (state_reg == ST_MUL_GO);
    assign div2_start = (state_reg == ST_VAR_GO) && sd_ok;
    assign sqrt_start = (state_reg == ST_SQRT_GO);

    rmv_div #(
        .NUM_W (SW),
        .DEN_W (CW)
    ) u_div_mean (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div1_start),
        .dividend (d0_mag[SW-1:0]),
        .divisor  (cnt_reg),
        .done     (div1_done),
        .quotient (div1_q)
    );

    rmv_mul #(
        .W (SW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (a_reg),
        .op_b    (d1_mag[SW-1:0]),
        .done    (mul_done),
        .product (prod)
    );

    rmv_div #(
        .NUM_W (MW),
        .DEN_W (CW)
    ) u_div_var (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div2_start),
        .dividend (m2_reg),
        .divisor  (cnt_reg - 1'b1),
        .done     (div2_done),
        .quotient (div2_q)
    );

    rmv_sqrt #(
        .RW (rmv_pkg::ROOT_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div2_q),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:    state_next = ST_DIV1;
            ST_DIV1: begin
                if (div1_done) begin
                    state_next = ST_MUL_GO;
                end
            end
            ST_MUL_GO:  state_next = ST_MUL;
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:     state_next = ST_VAR_GO;
            ST_VAR_GO:  state_next = sd_ok ? ST_DIV2 : ST_OUT;
            ST_DIV2: begin
                if (div2_done) begin
                    state_next = ST_SQRT_GO;
                end
            end
            ST_SQRT_GO: state_next = ST_SQRT;
            ST_SQRT: begin
                if (sqrt_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mean_reg      <= '0;
            m2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && s_tvalid && cnt_reg != '1) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == ST_DIV1 && div1_done) begin
                mean_reg <= mean_new;
            end
            if (state_reg == ST_ACC) begin
                m2_reg <= m2_sum[MW] ? '1 : m2_sum[MW-1:0];
            end
            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            x_reg <= s_tdata[SW-1:0];
        end
        if (state_reg == ST_LOAD) begin
            d0_neg_reg <= d0[SW];
            a_reg      <= d0_mag[SW-1:0];
        end
        if (state_reg == ST_MUL_GO) begin
            d1_neg_reg <= d1[SW];
            b_nz_reg   <= (d1 != '0);
        end
        if (state_reg == ST_VAR_GO && !sd_ok) begin
            sd_reg <= '0;
        end
        if (state_reg == ST_SQRT && sqrt_done) begin
            sd_reg <= sqrt_root;
        end
        if (state_reg == ST_OUT && out_free) begin
            out_data_reg <= {
                rmv_pkg::STD_FIELD_W'(sd_reg),
                m2_reg,
                rmv_pkg::MEAN_FIELD_W'($signed(mean_reg)),
                rmv_pkg::COUNT_FIELD_W'(cnt_reg)
            };
            out_flag_reg <= sd_ok;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_flag_reg;

endmodule

// ----- src/rmv_checker.sv -----
module rmv_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rmv_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser
);

    // held output beat stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // one sample at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a sample is in flight");

    // no deviation before two samples
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0]
            |-> m_tdata[rmv_pkg::STD_LSB +: rmv_pkg::STD_FIELD_W] == '0)
        else $error("std_dev set while flagged invalid");

    // flag implies count of at least two
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0]
            |-> m_tdata[rmv_pkg::COUNT_LSB + 1 +: rmv_pkg::COUNT_FIELD_W - 1] != '0)
        else $error("std_dev_valid with count below two");

    // reset drops the output
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind running_mean_variance_top rmv_checker u_rmv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
